@@ hw/rtl/cre_pkg.sv @@
// ----------------------------------------------------------------------------
// cre_pkg: shared types and constants of the competition rank engine
// Sizes, key and counter types, controller states and the command/status
// structs that run between the controller and the datapath.
// ----------------------------------------------------------------------------
package cre_pkg;

  localparam int unsigned CAPACITY = 64;
  localparam int unsigned KEY_BITS = 16;
  localparam int unsigned IDX_BITS = $clog2(CAPACITY);
  localparam int unsigned CNT_BITS = $clog2(CAPACITY + 1);

  typedef logic signed [KEY_BITS-1:0] key_t;
  typedef logic [IDX_BITS-1:0]        idx_t;
  typedef logic [CNT_BITS-1:0]        cnt_t;

  localparam cnt_t CAP_CNT = cnt_t'(CAPACITY);

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SCAN,
    ST_DRAIN,
    ST_EMIT
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;        // input transfer: store key or flag overflow
    logic scan_start;  // restart inner scan: j and greater count cleared
    logic scan_issue;  // read key j and step j
    logic i_next;      // advance to next record
    logic set_done;    // end of set: clear count, overflow and i
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic j_last;      // j addresses the last stored record
    logic i_last;      // i addresses the last stored record
  } sts_t;

endpackage

@@ hw/rtl/cre_if.sv @@
// ----------------------------------------------------------------------------
// cre_if: valid/ready channels of the competition rank engine
// One interface for the key input, one for the ranked results.
// ----------------------------------------------------------------------------
interface cre_in_if;
  logic          valid;
  logic          ready;
  cre_pkg::key_t key_value;
  logic          last_item;

  modport source (output valid, output key_value, output last_item, input ready);
  modport sink   (input valid, input key_value, input last_item, output ready);
endinterface

interface cre_out_if;
  logic          valid;
  logic          ready;
  cre_pkg::idx_t position;
  cre_pkg::key_t key_out;
  cre_pkg::cnt_t rank_out;
  logic          overflow;
  logic          last_result;

  modport source (output valid, output position, output key_out, output rank_out,
                  output overflow, output last_result, input ready);
  modport sink   (input valid, input position, input key_out, input rank_out,
                  input overflow, input last_result, output ready);
endinterface

@@ hw/rtl/cre_ctrl.sv @@
// ----------------------------------------------------------------------------
// cre_ctrl: sequencer of the competition rank engine
// Load phase, then per record a full scan of the key store and one result.
// ----------------------------------------------------------------------------
module cre_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_last_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  cre_pkg::sts_t  sts_i,
  output cre_pkg::cmd_t  cmd_o
);

  cre_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cre_pkg::ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      cre_pkg::ST_LOAD: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (in_last_i) begin
            cmd_o.scan_start = 1'b1;
            state_d          = cre_pkg::ST_SCAN;
          end
        end
      end
      cre_pkg::ST_SCAN: begin
        cmd_o.scan_issue = 1'b1;
        if (sts_i.j_last) begin
          state_d = cre_pkg::ST_DRAIN;
        end
      end
      // last compare result lands in the greater count
      cre_pkg::ST_DRAIN: begin
        state_d = cre_pkg::ST_EMIT;
      end
      cre_pkg::ST_EMIT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (sts_i.i_last) begin
            cmd_o.set_done = 1'b1;
            state_d        = cre_pkg::ST_LOAD;
          end else begin
            cmd_o.i_next     = 1'b1;
            cmd_o.scan_start = 1'b1;
            state_d          = cre_pkg::ST_SCAN;
          end
        end
      end
      default: begin
        state_d = cre_pkg::ST_LOAD;
      end
    endcase
  end

endmodule

@@ hw/rtl/cre_dp.sv @@
// ----------------------------------------------------------------------------
// cre_dp: datapath of the competition rank engine
// Key store memory (one write, two registered reads), record count, overflow
// flag, record/scan indexes and the greater-key counter.
// ----------------------------------------------------------------------------
module cre_dp (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  cre_pkg::cmd_t  cmd_i,
  input  cre_pkg::key_t  key_i,
  output cre_pkg::sts_t  sts_o,
  output cre_pkg::idx_t  position_o,
  output cre_pkg::key_t  key_o,
  output cre_pkg::cnt_t  rank_o,
  output logic           overflow_o
);

  cre_pkg::key_t mem_q [cre_pkg::CAPACITY];
  cre_pkg::key_t key_a_q, key_b_q;
  cre_pkg::cnt_t count_q, count_d;
  cre_pkg::cnt_t greater_q, greater_d;
  cre_pkg::idx_t i_q, i_d, j_q, j_d;
  cre_pkg::cnt_t last_idx;
  logic          ovf_q, ovf_d;
  logic          cmp_v_q;
  logic          full;

  assign full     = (count_q == cre_pkg::CAP_CNT);
  assign last_idx = cre_pkg::cnt_t'(count_q - 1'b1);

  // key store: write on load, port A reads record i, port B reads scan j
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && !full) begin
      mem_q[count_q[cre_pkg::IDX_BITS-1:0]] <= key_i;
    end
    key_a_q <= mem_q[i_q];
    key_b_q <= mem_q[j_q];
  end

  always_comb begin
    count_d   = count_q;
    ovf_d     = ovf_q;
    i_d       = i_q;
    j_d       = j_q;
    greater_d = greater_q;
    if (cmd_i.load) begin
      if (full) begin
        ovf_d = 1'b1;
      end else begin
        count_d = cre_pkg::cnt_t'(count_q + 1'b1);
      end
    end
    if (cmp_v_q && (key_b_q > key_a_q)) begin
      greater_d = cre_pkg::cnt_t'(greater_q + 1'b1);
    end
    if (cmd_i.scan_issue) begin
      j_d = cre_pkg::idx_t'(j_q + 1'b1);
    end
    if (cmd_i.scan_start) begin
      j_d       = '0;
      greater_d = '0;
    end
    if (cmd_i.i_next) begin
      i_d = cre_pkg::idx_t'(i_q + 1'b1);
    end
    if (cmd_i.set_done) begin
      i_d     = '0;
      count_d = '0;
      ovf_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      ovf_q     <= 1'b0;
      i_q       <= '0;
      j_q       <= '0;
      greater_q <= '0;
      cmp_v_q   <= 1'b0;
    end else begin
      count_q   <= count_d;
      ovf_q     <= ovf_d;
      i_q       <= i_d;
      j_q       <= j_d;
      greater_q <= greater_d;
      cmp_v_q   <= cmd_i.scan_issue;
    end
  end

  assign sts_o.j_last = (cre_pkg::cnt_t'(j_q) == last_idx);
  assign sts_o.i_last = (cre_pkg::cnt_t'(i_q) == last_idx);

  assign position_o = i_q;
  assign key_o      = key_a_q;
  assign rank_o     = cre_pkg::cnt_t'(greater_q + 1'b1);
  assign overflow_o = ovf_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= cre_pkg::CAP_CNT)
    else $error("record count above capacity");

  a_load_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load && !full && !cmd_i.set_done |=> count_q == $past(count_q) + 1'b1)
    else $error("stored key not counted");

  a_load_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load && full |=> ovf_q && count_q == $past(count_q))
    else $error("dropped key not flagged");

  a_set_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.set_done |=> count_q == '0 && !ovf_q && i_q == '0)
    else $error("set state not cleared");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan_issue |-> count_q != '0 && cre_pkg::cnt_t'(j_q) < count_q)
    else $error("scan past stored records");

endmodule

@@ hw/rtl/competition_rank_engine_core.sv @@
// ----------------------------------------------------------------------------
// competition_rank_engine_core: standard competition ranking of a key set
// Keys load in arrival order; on the last one every record is emitted with
// its position, key and rank (one plus the count of strictly greater keys).
// ----------------------------------------------------------------------------
// Use:
//   in_i  : one signed key per transfer; last_item marks the end of a set.
//           Up to CAPACITY keys are kept; extra keys are dropped and the
//           overflow bit of every result of that set is raised.
//   out_o : one result per stored record, in arrival order; last_result is
//           set on the final one. After it the block is ready for a new set.
// Timing:
//   Loading accepts one key per cycle (in_i.ready high, back to back).
//   Ranking scans the whole key store once per record through one read
//   port, then lets the last compare land and emits the result, which
//   waits on out_o.ready. The input is not ready while results are being
//   produced.
// Reset:
//   Asynchronous, active low; clears the record count, the overflow flag
//   and the sequencer. Key store contents are not reset.
// Stall:
//   A result is held stable on out_o until its transfer; the scan of the
//   next record starts only after it.
// ----------------------------------------------------------------------------
module competition_rank_engine_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  cre_in_if.sink     in_i,
  cre_out_if.source  out_o
);

  cre_pkg::cmd_t cmd;
  cre_pkg::sts_t sts;

  // sequencer: load phase, then scan / drain / emit per record
  cre_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_last_i   (in_i.last_item),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // key store and rank counting; result payload comes straight from its
  // registers, so it stays put while out_o is stalled
  cre_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .key_i      (in_i.key_value),
    .sts_o      (sts),
    .position_o (out_o.position),
    .key_o      (out_o.key_out),
    .rank_o     (out_o.rank_out),
    .overflow_o (out_o.overflow)
  );

  assign out_o.last_result = sts.i_last;

endmodule

@@ verif/cre_rank_check.sv @@
// ----------------------------------------------------------------------------
// cre_rank_check: key-set ranking predictor and result checker
// Watches both channels of the rank engine, keeps its own copy of the key
// store, predicts the ranked records of each set on its last key and
// compares every result transfer with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module cre_rank_check (
  input  logic clk_i,
  input  logic rst_ni,
  cre_in_if    keys_mon,
  cre_out_if   ranks_mon,
  output int   errors_o,
  output int   pending_o
);

  typedef struct {
    cre_pkg::idx_t position;
    cre_pkg::key_t key;
    cre_pkg::cnt_t rank;
    logic          overflow;
    logic          last_result;
  } ranked_rec_t;

  cre_pkg::key_t held_keys [cre_pkg::CAPACITY];
  int unsigned   held_count;
  logic          dropped;
  ranked_rec_t   ranked_q [$];
  int            mismatches = 0;

  assign errors_o = mismatches;

  // 1 + number of held keys strictly above the key at idx
  function automatic cre_pkg::cnt_t competition_rank(input int unsigned idx);
    int unsigned greater;
    greater = 0;
    for (int unsigned j = 0; j < held_count; j++) begin
      if (held_keys[j] > held_keys[idx]) greater++;
    end
    return cre_pkg::cnt_t'(greater + 1);
  endfunction

  // last key seen: queue one record per held key, then start a fresh set
  function automatic void rank_set();
    ranked_rec_t rec;
    for (int unsigned i = 0; i < held_count; i++) begin
      rec.position    = cre_pkg::idx_t'(i);
      rec.key         = held_keys[i];
      rec.rank        = competition_rank(i);
      rec.overflow    = dropped;
      rec.last_result = (i + 1 == held_count);
      ranked_q.push_back(rec);
    end
    held_count = 0;
    dropped    = 1'b0;
  endfunction

  function automatic void check_field(input string name, input logic signed [31:0] expv,
                                      input logic signed [31:0] actv);
    if (actv !== expv) begin
      mismatches++;
      $error("%s: expected %0d, got %0d", name, expv, actv);
    end
  endfunction

  function automatic void check_result();
    ranked_rec_t want;
    if (ranked_q.size() == 0) begin
      mismatches++;
      $error("result transfer with nothing expected: position %0d key %0d rank %0d",
             ranks_mon.position, ranks_mon.key_out, ranks_mon.rank_out);
      return;
    end
    want = ranked_q.pop_front();
    check_field("position",    want.position,    ranks_mon.position);
    check_field("key_out",     want.key,         ranks_mon.key_out);
    check_field("rank_out",    want.rank,        ranks_mon.rank_out);
    check_field("overflow",    want.overflow,    ranks_mon.overflow);
    check_field("last_result", want.last_result, ranks_mon.last_result);
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      held_count = 0;
      dropped    = 1'b0;
      ranked_q.delete();
    end else begin
      if (ranks_mon.valid && ranks_mon.ready) check_result();
      if (keys_mon.valid && keys_mon.ready) begin
        if (held_count < cre_pkg::CAPACITY) begin
          held_keys[held_count] = keys_mon.key_value;
          held_count++;
        end else begin
          dropped = 1'b1;
        end
        if (keys_mon.last_item) rank_set();
      end
    end
    pending_o = ranked_q.size();
  end

endmodule

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: testbench of the competition rank engine
// Sends key sets (directed corner sets, then random small sets with a full
// set and an overflowing set mixed in) with random gaps on the key side and
// random back-pressure on the result side; the rank checker beside the DUT
// predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned RANDOM_ITEMS = 146;  // keys in the random phase
  localparam int unsigned STEADY_ITEMS = 40;   // first random keys with no idling
  localparam cre_pkg::key_t KEY_MAX = {1'b0, {(cre_pkg::KEY_BITS-1){1'b1}}};
  localparam cre_pkg::key_t KEY_MIN = {1'b1, {(cre_pkg::KEY_BITS-1){1'b0}}};

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        steady;       // suppresses idling on both channels
  int          mismatches;
  int          awaiting;     // results predicted but not yet seen
  int unsigned small_sent;

  cre_in_if  keys_ch ();
  cre_out_if ranks_ch ();

  competition_rank_engine_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (keys_ch),
    .out_o  (ranks_ch)
  );

  cre_rank_check rank_check (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .keys_mon  (keys_ch),
    .ranks_mon (ranks_ch),
    .errors_o  (mismatches),
    .pending_o (awaiting)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // result-side back-pressure: ready dropped ~28% of cycles
  initial ranks_ch.ready = 1'b0;
  always @(posedge clk_i) begin
    ranks_ch.ready <= steady || ($urandom_range(99) >= 28);
  end

  // Random key: sometimes an extreme; otherwise full range when spread is zero,
  // else a narrow band around zero so that ties are common.
  function automatic cre_pkg::key_t random_key(input int unsigned spread);
    case ($urandom_range(9))
      0: return KEY_MIN;
      1: return KEY_MAX;
      default: begin
        if (spread == 0) return cre_pkg::key_t'($urandom);
        return cre_pkg::key_t'(int'($urandom_range(2 * spread)) - int'(spread));
      end
    endcase
  endfunction

  // one key transfer, after a random number of idle cycles
  task automatic send_key(input cre_pkg::key_t key, input logic last);
    while (!steady && $urandom_range(99) < 28) begin
      keys_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    keys_ch.valid     <= 1'b1;
    keys_ch.key_value <= key;
    keys_ch.last_item <= last;
    do @(posedge clk_i); while (keys_ch.ready !== 1'b1);
  endtask

  // n keys, the final one marked last
  task automatic send_set(input int unsigned n, input int unsigned spread);
    for (int unsigned i = 0; i < n; i++) send_key(random_key(spread), i + 1 == n);
  endtask

  // hold the key side idle until every predicted result has been seen
  task automatic wait_results_drained();
    keys_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (awaiting != 0) @(posedge clk_i);
  endtask

  initial begin
    int unsigned n;
    int unsigned spread;
    int          set_idx;

    rst_ni            = 1'b0;
    steady            = 1'b0;
    keys_ch.valid     = 1'b0;
    keys_ch.key_value = '0;
    keys_ch.last_item = 1'b0;
    small_sent        = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: one-key sets at both extremes
    send_key(KEY_MIN, 1'b1);
    send_key(KEY_MAX, 1'b1);
    // tie at the top, extremes and zero in one set
    send_key(KEY_MAX, 1'b0);
    send_key(KEY_MIN, 1'b0);
    send_key('0, 1'b0);
    send_key(KEY_MAX, 1'b1);
    // all keys equal: everyone ranks first
    send_key(cre_pkg::key_t'(5), 1'b0);
    send_key(cre_pkg::key_t'(5), 1'b0);
    send_key(cre_pkg::key_t'(5), 1'b1);
    // alternating bit patterns, -1 / 0 / +1
    send_key(cre_pkg::key_t'(16'h5555), 1'b0);
    send_key(cre_pkg::key_t'(16'hAAAA), 1'b0);
    send_key(cre_pkg::key_t'(-1), 1'b0);
    send_key(cre_pkg::key_t'(1), 1'b0);
    send_key('0, 1'b1);
    wait_results_drained();

    // random sets; one full set and one overflowing set ride along
    set_idx = 0;
    while (small_sent < RANDOM_ITEMS) begin
      steady = (small_sent < STEADY_ITEMS);
      spread = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 4);
      if (set_idx == 4) begin
        // last key lands in the final free entry: full, no overflow
        send_set(cre_pkg::CAPACITY, 0);
        small_sent += cre_pkg::CAPACITY;
      end else if (set_idx == 5) begin
        // store fills, extra keys and the last key itself are dropped
        n = cre_pkg::CAPACITY + $urandom_range(0, 3);
        for (int unsigned i = 0; i < n; i++) send_key(random_key(spread), 1'b0);
        send_key(random_key(spread), 1'b1);
        small_sent += n + 1;
      end else begin
        n = $urandom_range(1, 10);
        send_set(n, spread);
        small_sent += n;
      end
      if ($urandom_range(7) == 0) wait_results_drained();
      set_idx++;
    end
    steady = 1'b0;

    wait_results_drained();
    repeat (cre_pkg::CAPACITY + 4) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  // watchdog, far above the slowest legal run
  initial begin
    #10ms;
    $display("tb_top: errors");
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/cre_pkg.sv
hw/rtl/cre_if.sv
hw/rtl/cre_ctrl.sv
hw/rtl/cre_dp.sv
hw/rtl/competition_rank_engine_core.sv
verif/cre_rank_check.sv
verif/tb_top.sv
